// ===== rtl/core/gbk_pkg.sv =====
// ----------------------------------------------------------------------------
// gbk_pkg
// Shared codes and controller/datapath interface types for the sender.
// ----------------------------------------------------------------------------
`default_nettype none

package gbk_pkg;

  // request codes
  localparam logic [1:0] REQ_NEW   = 2'd0;
  localparam logic [1:0] REQ_ACK   = 2'd1;
  localparam logic [1:0] REQ_TIMER = 2'd2;

  // timer commands
  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  // most results one request may give, and the counter width for it
  localparam int RESULT_LIMIT = 16;
  localparam int CNT_W        = 5;

  localparam logic [4:0] WSIZE_RESET = 5'd8;

  typedef logic [CNT_W-1:0] cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic       store;      // write payload, bump fill count
    logic       take_ack;   // move window base past the ack
    logic       setup;      // arm the result run for the accepted request
    logic       resend;     // run walks base..next-1 instead of filling
    logic       run_one;    // run limited to a single packet
    logic       drop;       // result flags a dropped message
    logic [1:0] tcode;      // timer command for the first result
    logic       issue;      // read one packet, advance pointers
    logic       load_pkt;   // load output register with a packet
    logic       load_empty; // load output register with an empty result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       ack_good;
    logic       ack_newest;   // ack covers the newest packet sent
    logic       base_eq_next;
    logic       next_eq_count;
    logic       run_ok;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/go_back_n_sender_top.sv =====
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// Go-back-N ARQ sender: buffers messages, sends within the window, handles
// cumulative acks and retransmit timer expiry.
// ----------------------------------------------------------------------------
//
//  channel   signals                         direction  transaction
//  --------  ------------------------------  ---------  --------------------------
//  config    cfg_wr_en, cfg_wr_data          in         window size write, no wait
//  request   in_valid/in_ready + req fields  in         one event (msg/ack/timeout)
//  result    out_valid/out_ready + pkt/flags out        one result, last marks end
//
// Timing: an event is set up in the cycle it is taken; a run then passes the
//   start state, reading the first packet from the payload store's registered
//   read port, and the emit state, one packet per cycle while the output is not
//   stalled. An event with one empty result delivers it from the empty state.
// Ready is high whenever the controller is idle, even while the previous
//   transaction's final result still sits in the output register.
// A stalled output simply holds the run; nothing is lost or repeated.
// Reset clears the window counters and sets window size to 8; the payload
//   store has no clear, entries are always written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_top #(
  parameter int QUEUE_DEPTH = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [63:0] msg_data,
  input  wire logic [7:0]  ack_number,
  input  wire logic        ack_intact,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pkt_valid,
  output logic [7:0]       pkt_seq,
  output logic [63:0]      pkt_data,
  output logic [1:0]       timer_cmd,
  output logic             msg_dropped,
  output logic             last
);

  gbk_pkg::cmd_t    cmd;
  gbk_pkg::status_t st;

  // sequencing: decode in idle, then start/emit loop or a single empty result
  gbk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // counters, payload store and the output register
  gbk_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (req_type),
    .msg_data    (msg_data),
    .ack_number  (ack_number),
    .ack_intact  (ack_intact),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .pkt_valid   (pkt_valid),
    .pkt_seq     (pkt_seq),
    .pkt_data    (pkt_data),
    .timer_cmd   (timer_cmd),
    .msg_dropped (msg_dropped),
    .last        (last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gbk_dp.sv =====
// ----------------------------------------------------------------------------
// gbk_dp
// Sender datapath: window counters, payload store, run pointer, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_dp #(
  parameter int QUEUE_DEPTH = 256,
  parameter int MAX_WINDOW  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [4:0]       cfg_wr_data,
  input  wire logic [1:0]       req_type,
  input  wire logic [63:0]      msg_data,
  input  wire logic [7:0]       ack_number,
  input  wire logic             ack_intact,
  input  wire logic             out_ready,
  input  wire gbk_pkg::cmd_t    cmd,
  output gbk_pkg::status_t      st,
  output logic                  out_valid,
  output logic                  pkt_valid,
  output logic [7:0]            pkt_seq,
  output logic [63:0]           pkt_data,
  output logic [1:0]            timer_cmd,
  output logic                  msg_dropped,
  output logic                  last
);

  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int XW   = ((CW > 8) ? CW : 8) + 1;
  localparam int WMAX = (MAX_WINDOW < gbk_pkg::RESULT_LIMIT) ? MAX_WINDOW
                                                             : gbk_pkg::RESULT_LIMIT;

  logic [4:0]        window_size;
  logic [CW-1:0]     window_base;
  logic [CW-1:0]     next_sequence;
  logic [CW-1:0]     buffered_count;
  logic [CW-1:0]     cur;
  logic [CW-1:0]     seq_r;
  gbk_pkg::cnt_t     cnt;
  gbk_pkg::cnt_t     lim;
  logic              run_resend;
  logic [1:0]        tcode;
  logic              drop_flag;
  logic [63:0]       rd_data;
  logic [63:0]       mem [QUEUE_DEPTH];

  logic [4:0]        w_eff;
  logic [XW-1:0]     base_x, next_x, cur_x, ack_x, limit_x, ack_plus, seq_x;
  logic              run_ok;
  logic              out_free;
  logic              load;

  always_comb begin
    if (window_size == 5'd0) begin
      w_eff = 5'd1;
    end else if (window_size > 5'(WMAX)) begin
      w_eff = 5'(WMAX);
    end else begin
      w_eff = window_size;
    end
  end

  assign base_x   = {{(XW-CW){1'b0}}, window_base};
  assign next_x   = {{(XW-CW){1'b0}}, next_sequence};
  assign cur_x    = {{(XW-CW){1'b0}}, cur};
  assign seq_x    = {{(XW-CW){1'b0}}, seq_r};
  assign ack_x    = {{(XW-8){1'b0}}, ack_number};
  assign limit_x  = base_x + {{(XW-5){1'b0}}, w_eff};
  assign ack_plus = ack_x + XW'(1);

  // filling stops at the window edge, the last stored message or the run limit
  assign run_ok = (cnt < lim) &&
                  (run_resend ? (cur < next_sequence)
                              : ((cur_x < limit_x) && (cur < buffered_count)));

  assign out_free = !out_valid || out_ready;
  assign load     = cmd.load_pkt || cmd.load_empty;

  assign st.req           = req_type;
  assign st.full          = (buffered_count == CW'(QUEUE_DEPTH));
  assign st.ack_good      = ack_intact && (ack_x >= base_x) && (ack_x < next_x);
  assign st.ack_newest    = (ack_plus == next_x);
  assign st.base_eq_next  = (window_base == next_sequence);
  assign st.next_eq_count = (next_sequence == buffered_count);
  assign st.run_ok        = run_ok;
  assign st.out_free      = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= gbk_pkg::WSIZE_RESET;
      window_base    <= '0;
      next_sequence  <= '0;
      buffered_count <= '0;
      cur            <= '0;
      cnt            <= '0;
      lim            <= '0;
      run_resend     <= 1'b0;
      tcode          <= gbk_pkg::TMR_NONE;
      drop_flag      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end
      if (cmd.store) begin
        buffered_count <= buffered_count + CW'(1);
      end
      if (cmd.take_ack) begin
        window_base <= ack_plus[CW-1:0];
      end
      if (cmd.setup) begin
        cnt        <= '0;
        lim        <= cmd.run_one ? gbk_pkg::CNT_W'(1)
                                  : gbk_pkg::CNT_W'(gbk_pkg::RESULT_LIMIT);
        run_resend <= cmd.resend;
        cur        <= cmd.resend ? window_base : next_sequence;
        tcode      <= cmd.tcode;
        drop_flag  <= cmd.drop;
      end
      if (cmd.issue) begin
        cur <= cur + CW'(1);
        cnt <= cnt + gbk_pkg::CNT_W'(1);
        if (!run_resend) begin
          next_sequence <= next_sequence + CW'(1);
        end
      end
      // timer command rides on the first result only
      if (load) begin
        tcode     <= gbk_pkg::TMR_NONE;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[buffered_count[AW-1:0]] <= msg_data;
    end
    if (cmd.issue) begin
      rd_data <= mem[cur[AW-1:0]];
      seq_r   <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      pkt_valid   <= 1'b1;
      pkt_seq     <= seq_x[7:0];
      pkt_data    <= rd_data;
      timer_cmd   <= tcode;
      msg_dropped <= 1'b0;
      last        <= !run_ok;
    end else if (cmd.load_empty) begin
      pkt_valid   <= 1'b0;
      pkt_seq     <= 8'd0;
      pkt_data    <= 64'd0;
      timer_cmd   <= tcode;
      msg_dropped <= drop_flag;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbk_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbk_ctrl
// Sender controller: decodes a request and sequences its result run.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire gbk_pkg::status_t st,
  output gbk_pkg::cmd_t         cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_EMPTY = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.setup  = 1'b1;
          state_next = S_EMPTY;
          case (st.req)
            gbk_pkg::REQ_NEW: begin
              if (st.full) begin
                cmd.drop = 1'b1;
              end else begin
                cmd.store   = 1'b1;
                cmd.run_one = 1'b1;
                cmd.tcode   = st.base_eq_next ? gbk_pkg::TMR_START : gbk_pkg::TMR_NONE;
                state_next  = S_START;
              end
            end
            gbk_pkg::REQ_ACK: begin
              if (st.ack_good) begin
                cmd.take_ack = 1'b1;
                // nothing left in flight only if the ack covers all sent and
                // nothing is waiting to go
                cmd.tcode    = (st.ack_newest && st.next_eq_count) ? gbk_pkg::TMR_STOP
                                                                   : gbk_pkg::TMR_START;
                state_next   = S_START;
              end
            end
            gbk_pkg::REQ_TIMER: begin
              cmd.resend = 1'b1;
              cmd.tcode  = gbk_pkg::TMR_START;
              state_next = S_START;
            end
            default: begin
              state_next = S_EMPTY;
            end
          endcase
        end
      end
      S_START: begin
        if (st.run_ok) begin
          cmd.issue  = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_EMPTY;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_pkt = 1'b1;
          if (st.run_ok) begin
            cmd.issue = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.load_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbk_chk.sv =====
// ----------------------------------------------------------------------------
// gbk_chk
// Port-level checks for the sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbk_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        pkt_valid,
  input wire logic [7:0]  pkt_seq,
  input wire logic [63:0] pkt_data,
  input wire logic [1:0]  timer_cmd,
  input wire logic        msg_dropped,
  input wire logic        last
);

  // one transaction at a time: ready drops straight after a take
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still running");

  a_timer_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (timer_cmd == gbk_pkg::TMR_NONE) || (timer_cmd == gbk_pkg::TMR_START) ||
                  (timer_cmd == gbk_pkg::TMR_STOP))
    else $error("undefined timer command");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pkt_valid |-> (pkt_seq == 8'd0) && (pkt_data == 64'd0))
    else $error("empty result carries packet fields");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_dropped |-> last && !pkt_valid && (timer_cmd == gbk_pkg::TMR_NONE))
    else $error("drop flag on a result that is not a lone empty one");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pkt_data) && $stable(last))
    else $error("stalled result changed");

endmodule

bind go_back_n_sender_top gbk_chk u_chk (.*);

`default_nettype wire
